// ===== hw/rtl/thavg_pkg.sv =====
`timescale 1ns / 1ps

package thavg_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned ADC_W     = 16;   // width that holds any ADC full-scale code
  localparam int unsigned RS_W      = 20;
  localparam int unsigned BETA_W    = 16;
  localparam int unsigned TEMPC_W   = 9;
  localparam int unsigned RES_W     = 32;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 20;

  // Default parameter values
  localparam int unsigned SAMPLES_DEF = 5;
  localparam int unsigned ADC_MAX_DEF = 4095;

  // Fixed-point constants
  localparam int unsigned FRAC_W   = 32;            // log2 fraction bits
  localparam int unsigned LN2_W    = 24;
  localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
  localparam int unsigned LN_SHIFT = 16;            // Q56 -> Q40
  localparam int unsigned Q_SHIFT  = 40;
  localparam int unsigned CENTI_ONE = 100;
  localparam int unsigned KELVIN_CENTI = 27315;
  localparam int unsigned TCK_MAX = 100000;
  localparam int unsigned TCK_W   = 17;
  localparam logic signed [TEMP_W-1:0] TEMP_HI = 16'sh7FFF;

  // Register reset values
  localparam logic [RS_W-1:0]    RS_RESET    = 20'd10000;
  localparam logic [RS_W-1:0]    RN_RESET    = 20'd10000;
  localparam logic [BETA_W-1:0]  BETA_RESET  = 16'd12920;
  localparam logic [TEMPC_W-1:0] TEMPC_RESET = 9'd25;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_OPEN  = 2'd1,
    STAT_SHORT = 2'd2,
    STAT_SAT   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERIES  = 2'd0,
    CFG_NOMINAL = 2'd1,
    CFG_BETA    = 2'd2,
    CFG_T0      = 2'd3
  } cfg_idx_e;

endpackage

// ===== hw/rtl/thavg_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module thavg_div
  import thavg_pkg::*;
#(
  parameter int unsigned W = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  dvs_q;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  // Shift the next dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hw/rtl/thavg_log2.sv =====
`timescale 1ns / 1ps

// log2 in Q32: serial normalize, then one squaring per fraction bit
module thavg_log2
  import thavg_pkg::*;
#(
  parameter int unsigned NW = 35,
  localparam int unsigned KW = $clog2(NW),
  localparam int unsigned LOGW = FRAC_W + KW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NW-1:0]   n_i,
  output logic            done_o,
  output logic [LOGW-1:0] log_o
);

  localparam int unsigned PW   = 2 * FRAC_W;
  localparam int unsigned IT_W = $clog2(FRAC_W);

  logic              norm_q;
  logic              sq_q;
  logic              done_q;
  logic [IT_W-1:0]   it_q;
  logic [NW-1:0]     m_q;
  logic [KW-1:0]     k_q;
  logic [FRAC_W-1:0] y_q;
  logic [FRAC_W-1:0] frac_q;

  logic [NW+FRAC_W-1:0] mext;
  logic [PW-1:0]        sq;
  logic [FRAC_W:0]      p;
  logic [FRAC_W-1:0]    y_next;

  assign mext   = {m_q, {FRAC_W{1'b0}}};
  assign sq     = PW'(y_q) * PW'(y_q);
  assign p      = sq[PW-1:FRAC_W-1];
  assign y_next = p[FRAC_W] ? p[FRAC_W:1] : p[FRAC_W-1:0];

  // Phase control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= 1'b0;
      sq_q   <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        norm_q <= 1'b1;
        sq_q   <= 1'b0;
      end else if (norm_q && m_q[NW-1]) begin
        norm_q <= 1'b0;
        sq_q   <= 1'b1;
        it_q   <= '0;
      end else if (sq_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == IT_W'(FRAC_W - 1)) begin
          sq_q   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift left until the msb is set, then square
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q <= n_i;
      k_q <= KW'(NW - 1);
    end else if (norm_q) begin
      if (m_q[NW-1]) begin
        y_q    <= mext[NW+FRAC_W-1 -: FRAC_W];
        frac_q <= '0;
      end else begin
        m_q <= {m_q[NW-2:0], 1'b0};
        k_q <= k_q - 1'b1;
      end
    end else if (sq_q) begin
      y_q    <= y_next;
      frac_q <= {frac_q[FRAC_W-2:0], p[FRAC_W]};
    end
  end

  assign done_o = done_q;
  assign log_o  = {k_q, frac_q};

endmodule

// ===== hw/rtl/thermistor_average_to_celsius_top.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  adc_sample_i
// out      output     out_valid_o / out_stall_i resistance_ohms_o, temp_centi_c_o, status_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample that does not close a batch is accepted and leaves the block idle.
// The sample that closes a batch starts a conversion that makes up to four passes of the
// bit-serial divider and two runs of the log2 squaring unit; in_stall_o is high meanwhile.
// Faulted batches (open, short, zero series resistor) go from the prepare state straight
// to the finish state, with no divider or log2 run.
// Reset is asynchronous, active low, and clears the sum, the count and the registers to
// their defaults. A stalled result waits in the output register; the block holds the
// next conversion's result until the output register is free.
module thermistor_average_to_celsius_top
  import thavg_pkg::*;
#(
  parameter int unsigned SAMPLES = SAMPLES_DEF,
  parameter int unsigned ADC_MAX = ADC_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [SAMPLE_W-1:0]        adc_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [RES_W-1:0]           resistance_ohms_o,
  output logic signed [TEMP_W-1:0]   temp_centi_c_o,
  output logic [STAT_W-1:0]          status_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DAT_W-1:0]       cfg_data_i
);

  localparam int unsigned FULL_L = ADC_MAX * SAMPLES;
  localparam int unsigned SUM_W  = $clog2(FULL_L + 1);
  localparam int unsigned CNT_W  = $clog2(SAMPLES + 1);
  localparam int unsigned NW     = RS_W + SUM_W;
  localparam int unsigned KW     = $clog2(NW);
  localparam int unsigned LOGW   = FRAC_W + KW;
  localparam int unsigned AW     = LOGW + LN2_W;
  localparam int unsigned MC_W   = $clog2(LN2_W);
  localparam int unsigned DW_A   = (LOGW + 9 > 48) ? LOGW + 9 : 48;
  localparam int unsigned DW     = (NW + 1 > DW_A) ? NW + 1 : DW_A;

  localparam logic [SUM_W-1:0] FULL    = SUM_W'(FULL_L);
  localparam logic [ADC_W-1:0] ADC_LIM = ADC_W'(ADC_MAX);
  localparam logic [DW-1:0]    CENTI_Q = DW'(CENTI_ONE) << Q_SHIFT;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_PREP = 11'b00000000010,
    ST_RDIV = 11'b00000000100,
    ST_LOG1 = 11'b00000001000,
    ST_LOG2 = 11'b00000010000,
    ST_MUL  = 11'b00000100000,
    ST_TDIV = 11'b00001000000,
    ST_IDIV = 11'b00010000000,
    ST_SUM  = 11'b00100000000,
    ST_KDIV = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   launched_q;

  logic [RS_W-1:0]    rs_q;
  logic [RS_W-1:0]    rn_q;
  logic [BETA_W-1:0]  beta_q;
  logic [TEMPC_W-1:0] t0_q;

  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0] s_q;
  logic [NW-1:0]    num_q;
  logic [NW-1:0]    den_q;
  logic [LOGW-1:0]  l1_q;
  logic [LOGW-1:0]  mag_q;
  logic             neg_q;
  logic [AW-1:0]    acc_q;
  logic [MC_W-1:0]  mcnt_q;
  logic [DW-1:0]    term_q;
  logic [DW-1:0]    invt0_q;
  logic [DW-1:0]    u_q;

  logic [RES_W-1:0]         res_r_q;
  logic signed [TEMP_W-1:0] temp_r_q;
  status_e                  stat_r_q;

  logic                     out_valid_q;
  logic [RES_W-1:0]         out_res_q;
  logic signed [TEMP_W-1:0] out_temp_q;
  status_e                  out_stat_q;

  // Sample clamp and accumulate
  logic [ADC_W-1:0] smp_ext;
  logic [ADC_W-1:0] smp_clamp;
  logic [SUM_W-1:0] sum_add;
  logic             in_acc;
  logic             last;

  assign smp_ext   = ADC_W'(adc_sample_i);
  assign smp_clamp = (smp_ext > ADC_LIM) ? ADC_LIM : smp_ext;
  assign sum_add   = sum_q + SUM_W'(smp_clamp);
  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign last      = (cnt_q == CNT_W'(SAMPLES - 1));

  // Divider ratio terms
  logic [RS_W-1:0]   rn_eff;
  logic [BETA_W-1:0] beta_eff;
  logic [NW-1:0]     num;
  logic [NW-1:0]     den;
  logic              fault;

  assign rn_eff   = (rn_q == '0) ? RS_W'(1) : rn_q;
  assign beta_eff = (beta_q == '0) ? BETA_W'(1) : beta_q;
  assign num      = NW'(rs_q) * NW'(FULL - s_q);
  assign den      = NW'(s_q) * NW'(rn_eff);
  assign fault    = (s_q == '0) || (s_q >= FULL) || (rs_q == '0);

  // Nominal temperature in centikelvin
  logic signed [TCK_W:0] t0c_s;
  logic [TCK_W-1:0]      t0c;

  assign t0c_s = (TCK_W + 1)'($signed(t0_q)) * (TCK_W + 1)'(CENTI_ONE)
               + (TCK_W + 1)'(KELVIN_CENTI);
  assign t0c   = t0c_s[TCK_W-1:0];

  // Shared divider
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_a;
  logic [DW-1:0] div_b;
  logic [DW-1:0] div_q;

  assign div_start = !launched_q && ((state_q == ST_RDIV) || (state_q == ST_TDIV) ||
                                     (state_q == ST_IDIV) || (state_q == ST_KDIV));

  always_comb begin
    case (state_q)
      ST_RDIV: begin
        div_a = DW'(num_q) + DW'(s_q >> 1);
        div_b = DW'(s_q);
      end
      ST_TDIV: begin
        div_a = DW'(acc_q[AW-1:LN_SHIFT]);
        div_b = DW'(beta_eff);
      end
      ST_IDIV: begin
        div_a = CENTI_Q + DW'(t0c >> 1);
        div_b = DW'(t0c);
      end
      ST_KDIV: begin
        div_a = CENTI_Q + (u_q >> 1);
        div_b = u_q;
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  thavg_div #(
    .W (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // Shared log2 unit
  logic            log_start;
  logic            log_done;
  logic [LOGW-1:0] log_val;

  assign log_start = !launched_q && ((state_q == ST_LOG1) || (state_q == ST_LOG2));

  thavg_log2 #(
    .NW (NW)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .n_i     ((state_q == ST_LOG1) ? num_q : den_q),
    .done_o  (log_done),
    .log_o   (log_val)
  );

  // 1/T in Q40 and final temperature
  logic signed [DW:0]    u_s;
  logic                  u_pos;
  logic [TCK_W-1:0]      tck_c;
  logic signed [TCK_W:0] temp_full;
  logic                  temp_over;

  assign u_s = neg_q ? ($signed({1'b0, invt0_q}) - $signed({1'b0, term_q}))
                     : ($signed({1'b0, invt0_q}) + $signed({1'b0, term_q}));
  assign u_pos     = !u_s[DW] && (u_s != '0);
  assign tck_c     = (div_q > DW'(TCK_MAX)) ? TCK_W'(TCK_MAX) : div_q[TCK_W-1:0];
  assign temp_full = $signed({1'b0, tck_c}) - (TCK_W + 1)'(KELVIN_CENTI);
  assign temp_over = temp_full > (TCK_W + 1)'(TEMP_HI);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && last) state_d = ST_PREP;
      ST_PREP: state_d = fault ? ST_FIN : ST_RDIV;
      ST_RDIV: if (div_done) state_d = ST_LOG1;
      ST_LOG1: if (log_done) state_d = ST_LOG2;
      ST_LOG2: if (log_done) state_d = ST_MUL;
      ST_MUL:  if (mcnt_q == '0) state_d = ST_TDIV;
      ST_TDIV: if (div_done) state_d = ST_IDIV;
      ST_IDIV: if (div_done) state_d = ST_SUM;
      ST_SUM:  state_d = u_pos ? ST_KDIV : ST_FIN;
      ST_KDIV: if (div_done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rs_q        <= RS_RESET;
      rn_q        <= RN_RESET;
      beta_q      <= BETA_RESET;
      t0_q        <= TEMPC_RESET;
    end else begin
      state_q <= state_d;
      if (div_done || log_done) begin
        launched_q <= 1'b0;
      end else if (div_start || log_start) begin
        launched_q <= 1'b1;
      end
      if (in_acc) begin
        if (last) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_add;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SERIES:  rs_q   <= cfg_data_i[RS_W-1:0];
          CFG_NOMINAL: rn_q   <= cfg_data_i[RS_W-1:0];
          CFG_BETA:    beta_q <= cfg_data_i[BETA_W-1:0];
          CFG_T0:      t0_q   <= cfg_data_i[TEMPC_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc && last) s_q <= sum_add;
      end
      ST_PREP: begin
        num_q <= num;
        den_q <= den;
        if (s_q == '0) begin
          res_r_q  <= '1;
          temp_r_q <= '0;
          stat_r_q <= STAT_OPEN;
        end else if (s_q >= FULL) begin
          res_r_q  <= '0;
          temp_r_q <= '0;
          stat_r_q <= STAT_SHORT;
        end else if (rs_q == '0) begin
          res_r_q  <= '0;
          temp_r_q <= TEMP_HI;
          stat_r_q <= STAT_SAT;
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          if (|div_q[DW-1:RES_W]) begin
            res_r_q  <= '1;
            stat_r_q <= STAT_SAT;
          end else begin
            res_r_q  <= div_q[RES_W-1:0];
            stat_r_q <= STAT_OK;
          end
        end
      end
      ST_LOG1: begin
        if (log_done) l1_q <= log_val;
      end
      ST_LOG2: begin
        if (log_done) begin
          neg_q  <= (l1_q < log_val);
          mag_q  <= (l1_q < log_val) ? (log_val - l1_q) : (l1_q - log_val);
          acc_q  <= '0;
          mcnt_q <= MC_W'(LN2_W - 1);
        end
      end
      // mag * ln2, one constant bit per cycle, msb first
      ST_MUL: begin
        acc_q  <= {acc_q[AW-2:0], 1'b0} + (LN2_Q24[mcnt_q] ? AW'(mag_q) : AW'(0));
        mcnt_q <= mcnt_q - 1'b1;
      end
      ST_TDIV: begin
        if (div_done) term_q <= div_q;
      end
      ST_IDIV: begin
        if (div_done) invt0_q <= div_q;
      end
      ST_SUM: begin
        u_q <= u_s[DW-1:0];
        if (!u_pos) begin
          temp_r_q <= TEMP_HI;
          stat_r_q <= STAT_SAT;
        end
      end
      ST_KDIV: begin
        if (div_done) begin
          if (temp_over) begin
            temp_r_q <= TEMP_HI;
            stat_r_q <= STAT_SAT;
          end else begin
            temp_r_q <= temp_full[TEMP_W-1:0];
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_res_q  <= res_r_q;
          out_temp_q <= temp_r_q;
          out_stat_q <= stat_r_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign resistance_ohms_o = out_res_q;
  assign temp_centi_c_o    = out_temp_q;
  assign status_o          = out_stat_q;
  assign cfg_ready_o       = 1'b1;

endmodule

// ===== hw/rtl/thavg_checker.sv =====
`timescale 1ns / 1ps

module thavg_checker
  import thavg_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [SAMPLE_W-1:0]      adc_sample_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [RES_W-1:0]         resistance_ohms_o,
  input logic signed [TEMP_W-1:0] temp_centi_c_o,
  input logic [STAT_W-1:0]        status_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o,
  input logic [CFG_IDX_W-1:0]     cfg_index_i,
  input logic [CFG_DAT_W-1:0]     cfg_data_i
);

  // Open sensor word: full-scale resistance, zero temperature
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OPEN |->
      resistance_ohms_o == '1 && temp_centi_c_o == '0)
    else $error("open word has wrong fields");

  // Shorted sensor word: zero resistance, zero temperature
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_SHORT |->
      resistance_ohms_o == '0 && temp_centi_c_o == '0)
    else $error("short word has wrong fields");

  // A clean word never lies below absolute zero
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_OK |->
      temp_centi_c_o >= -$signed(TEMP_W'(KELVIN_CENTI)))
    else $error("clean word below absolute zero");

  // A new word only appears after a conversion that held off input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a conversion");

  // Stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(resistance_ohms_o)
      && $stable(temp_centi_c_o) && $stable(status_o))
    else $error("stalled word changed");

endmodule

bind thermistor_average_to_celsius_top thavg_checker u_thavg_checker (.*);

// ===== sim/thermistor_average_to_celsius_top_tb.sv =====
`timescale 1ns / 1ps

module thermistor_average_to_celsius_top_tb;
  import thavg_pkg::*;

  localparam int unsigned N_SAMPLES  = SAMPLES_DEF;
  localparam int unsigned FULL_SCALE = ADC_MAX_DEF;
  localparam int unsigned CONV_WAIT  = 450;   // a bit over one conversion

  // Conversion result word
  typedef struct packed {
    logic [RES_W-1:0]         ohms;
    logic signed [TEMP_W-1:0] centi;
    status_e                  stat;
  } conv_word_t;

  // Tracks the averaging state and predicts each batch conversion
  class conversion_tracker;
    logic [RS_W-1:0]    series_ohms;
    logic [RS_W-1:0]    nominal_ohms;
    logic [BETA_W-1:0]  beta_k;
    logic [TEMPC_W-1:0] t0_deg;
    int unsigned        batch_sum;
    int unsigned        batch_cnt;
    conv_word_t         pending_words[$];
    int unsigned        errors;

    function new();
      series_ohms  = RS_RESET;
      nominal_ohms = RN_RESET;
      beta_k       = BETA_RESET;
      t0_deg       = TEMPC_RESET;
      batch_sum    = 0;
      batch_cnt    = 0;
      errors       = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] d);
      case (idx)
        CFG_SERIES:  series_ohms  = d[RS_W-1:0];
        CFG_NOMINAL: nominal_ohms = d[RS_W-1:0];
        CFG_BETA:    beta_k       = d[BETA_W-1:0];
        CFG_T0:      t0_deg       = d[TEMPC_W-1:0];
        default: ;
      endcase
    endfunction

    // log2 in Q32: normalize, then square 32 times with truncation
    function logic [63:0] log2_q32(logic [63:0] n);
      int unsigned k;
      logic [63:0] y;
      logic [63:0] frac;
      k = 0;
      frac = 0;
      for (int b = 0; b < 64; b++) if (n[b]) k = b;
      y = (k >= 31) ? (n >> (k - 31)) : (n << (31 - k));
      for (int i = 0; i < 32; i++) begin
        y = (y * y) >> 31;
        frac = frac << 1;
        if (y >= 64'h1_0000_0000) begin
          y = y >> 1;
          frac[0] = 1'b1;
        end
      end
      return (64'(k) << 32) | frac;
    endfunction

    function conv_word_t convert_sum(logic [63:0] s);
      conv_word_t w;
      logic [63:0] full, rs, rn, bt, num, den, res, l1, l2, mag, term, t0c, invt0, uu, tck;
      logic signed [63:0] u, temp;
      logic neg;
      full = 64'(FULL_SCALE) * 64'(N_SAMPLES);
      w.stat = STAT_OK;
      if (s == 0) begin
        w.ohms = '1; w.centi = '0; w.stat = STAT_OPEN;
        return w;
      end
      if (s >= full) begin
        w.ohms = '0; w.centi = '0; w.stat = STAT_SHORT;
        return w;
      end
      rs  = 64'(series_ohms);
      rn  = (nominal_ohms != 0) ? 64'(nominal_ohms) : 64'd1;
      bt  = (beta_k != 0) ? 64'(beta_k) : 64'd1;
      num = rs * (full - s);
      if (num == 0) begin
        w.ohms = '0; w.centi = TEMP_HI; w.stat = STAT_SAT;
        return w;
      end
      res = (num + s / 2) / s;
      if (res > 64'hFFFF_FFFF) begin
        res = 64'hFFFF_FFFF;
        w.stat = STAT_SAT;
      end
      den  = s * rn;
      l1   = log2_q32(num);
      l2   = log2_q32(den);
      neg  = l1 < l2;
      mag  = neg ? (l2 - l1) : (l1 - l2);
      term = ((mag * 64'(LN2_Q24)) >> LN_SHIFT) / bt;
      t0c  = 64'(int'($signed(t0_deg)) * 100 + int'(KELVIN_CENTI));
      invt0 = ((64'(CENTI_ONE) << Q_SHIFT) + t0c / 2) / t0c;
      u = neg ? ($signed(invt0) - $signed(term)) : ($signed(invt0) + $signed(term));
      if (u <= 0) begin
        temp = 32767;
        w.stat = STAT_SAT;
      end else begin
        uu  = u;
        tck = ((64'(CENTI_ONE) << Q_SHIFT) + uu / 2) / uu;
        if (tck > 64'(TCK_MAX)) tck = 64'(TCK_MAX);
        temp = $signed(tck) - 64'(int'(KELVIN_CENTI));
        if (temp > 32767) begin
          temp = 32767;
          w.stat = STAT_SAT;
        end else if (temp < -int'(KELVIN_CENTI)) begin
          temp = -int'(KELVIN_CENTI);
          w.stat = STAT_SAT;
        end
      end
      w.ohms  = res[RES_W-1:0];
      w.centi = temp[TEMP_W-1:0];
      return w;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] smp);
      int unsigned v;
      v = (smp > FULL_SCALE) ? FULL_SCALE : smp;
      batch_sum += v;
      batch_cnt++;
      if (batch_cnt == N_SAMPLES) begin
        pending_words.push_back(convert_sum(64'(batch_sum)));
        batch_sum = 0;
        batch_cnt = 0;
      end
    endfunction

    function void check_word(logic [RES_W-1:0] ohms, logic signed [TEMP_W-1:0] centi,
                             logic [STAT_W-1:0] stat);
      conv_word_t e;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word ohms=%0d temp=%0d status=%0d",
                 $time, ohms, centi, stat);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      if (ohms !== e.ohms) begin
        $display("%0t: resistance exp=%0d got=%0d", $time, e.ohms, ohms);
        errors++;
      end
      if (centi !== e.centi) begin
        $display("%0t: temperature exp=%0d got=%0d", $time, e.centi, centi);
        errors++;
      end
      if (stat !== e.stat) begin
        $display("%0t: status exp=%0d got=%0d", $time, e.stat, stat);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [SAMPLE_W-1:0]      adc_sample_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [RES_W-1:0]         resistance_ohms_o;
  logic signed [TEMP_W-1:0] temp_centi_c_o;
  logic [STAT_W-1:0]        status_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]     cfg_data_i = '0;

  conversion_tracker tracker = new();
  int unsigned       hold_req = 0;
  bit                quiet_out = 1'b0;

  thermistor_average_to_celsius_top u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .adc_sample_i     (adc_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .resistance_ohms_o(resistance_ohms_o),
    .temp_centi_c_o   (temp_centi_c_o),
    .status_o         (status_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #10 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 80);
  endfunction

  // Result side: checks each accepted word; random stalls and long holds, a long hold on request, none when quiet
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid_o && !out_stall_i)
        tracker.check_word(resistance_ohms_o, temp_centi_c_o, status_o);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (quiet_out) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 2) hold_left = $urandom_range(20, 120);
      end
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] smp);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    adc_sample_i <= smp;
    do @(posedge clk); while (in_stall_o);
    tracker.note_sample(smp);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Valid stays high across back-to-back writes; the caller drops it after the last one
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    tracker.write_reg(idx, d);
  endtask

  // Wait for every expected word, then let any batch in flight settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (CONV_WAIT) @(posedge clk);
  endtask

  task automatic send_batch(int unsigned mode);
    logic [SAMPLE_W-1:0] base;
    base = SAMPLE_W'($urandom_range(0, FULL_SCALE));
    for (int i = 0; i < N_SAMPLES; i++) begin
      case (mode)
        0: send_sample(SAMPLE_W'($urandom_range(0, FULL_SCALE)));
        1: send_sample(base);
        2: send_sample(SAMPLE_W'($urandom_range(0, 40)));
        3: send_sample(SAMPLE_W'($urandom_range(FULL_SCALE - 40, FULL_SCALE)));
        4: send_sample('0);
        5: send_sample('1);
        default: send_sample(base ^ SAMPLE_W'($urandom_range(0, 7)));
      endcase
    end
  endtask

  initial begin
    logic [CFG_DAT_W-1:0] settings[8][4];
    settings = '{
      '{20'd10000,   20'd10000,   20'd12920, 20'd25},
      '{20'hFFFFF,   20'd1,       20'd1,     20'h100},   // max Rs, min Rn/beta, -256 C
      '{20'd1,       20'hFFFFF,   20'hFFFF,  20'h0FF},   // 255 C
      '{20'd0,       20'd10000,   20'd3950,  20'd25},    // zero series resistor
      '{20'd4700,    20'd0,       20'd0,     20'h1C9},   // zero Rn/beta, -55 C
      '{20'd100000,  20'd100000,  20'd4250,  20'd150},
      '{20'd1000000, 20'd1000,    20'd65535, 20'd0},
      '{20'd2200,    20'd47000,   20'd3380,  20'h1F6}
    };

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: open, short, full-scale mix, single counts, near-full
    send_batch(4);
    send_batch(5);
    send_sample('1); send_sample('0); send_sample('1); send_sample('0); send_sample(12'hAAA);
    send_sample(12'd1); send_sample('0); send_sample('0); send_sample('0); send_sample('0);
    send_sample(12'hFFE); send_sample('1); send_sample('1); send_sample('1); send_sample('1);
    drain();

    for (int p = 0; p < 8; p++) begin
      for (int r = 0; r < 4; r++) write_reg(cfg_idx_e'(r), settings[p][r]);
      cfg_valid_i <= 1'b0;
      send_batch(4);
      send_batch(5);
      if (p == 2) begin
        hold_req = 1500;   // result side backs up while samples keep coming
        repeat (6) send_batch(0);
      end
      for (int b = 0; b < 13; b++) begin
        send_batch($urandom_range(0, 99) < 55 ? 0 : $urandom_range(1, 6));
        if ($urandom_range(0, 99) < 8) begin
          in_valid_i <= 1'b0;
          @(posedge clk);
          while (tracker.pending_words.size() != 0) @(posedge clk);
        end
      end
      // trailing partial batch carries into the next setting
      send_sample(SAMPLE_W'($urandom_range(0, FULL_SCALE)));
      quiet_out = (p == 7);
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_words.size() == 0) begin
      $display("thermistor_average_to_celsius_top regression: pass");
    end else begin
      $display("thermistor_average_to_celsius_top regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("thermistor_average_to_celsius_top regression: fail");
    $finish;
  end

endmodule
